/* rtl/ialu_pkg.sv */
package ialu_pkg;

    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_WIDTH  = 4;
    localparam int ERR_WIDTH = 2;

    localparam logic [OP_WIDTH-1:0] OP_ADD = 4'd0;
    localparam logic [OP_WIDTH-1:0] OP_SUB = 4'd1;
    localparam logic [OP_WIDTH-1:0] OP_MUL = 4'd2;
    localparam logic [OP_WIDTH-1:0] OP_DIV = 4'd3;
    localparam logic [OP_WIDTH-1:0] OP_MOD = 4'd4;
    localparam logic [OP_WIDTH-1:0] OP_POW = 4'd5;
    localparam logic [OP_WIDTH-1:0] OP_NEG = 4'd6;
    localparam logic [OP_WIDTH-1:0] OP_EQ  = 4'd7;
    localparam logic [OP_WIDTH-1:0] OP_GT  = 4'd8;
    localparam logic [OP_WIDTH-1:0] OP_LT  = 4'd9;

    localparam logic [ERR_WIDTH-1:0] ERR_NONE    = 2'd0;
    localparam logic [ERR_WIDTH-1:0] ERR_DIV_ZERO = 2'd1;
    localparam logic [ERR_WIDTH-1:0] ERR_MOD_ZERO = 2'd2;
    localparam logic [ERR_WIDTH-1:0] ERR_NEG_EXP  = 2'd3;

endpackage

/* rtl/integer_alu_floor_mod_power.sv */
// Sequencing from input accept to result valid: add, sub, neg and compares pass through ST_ALU;
// unused codes, a zero divisor or a negative exponent go straight to ST_DONE; multiply is
// shift-and-add and stops once the multiplier is spent; divide and modulo take magnitudes,
// run a restoring divider and fix the signs. Power squares and multiplies through the same adder.
// One item is in work at a time; the next is taken the cycle after the result is registered.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle and drops m_valid.
module integer_alu_floor_mod_power #(
    parameter int DATA_WIDTH = ialu_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [ialu_pkg::OP_WIDTH-1:0]       s_operation,
    input  logic signed [DATA_WIDTH-1:0]        s_left_value,
    input  logic signed [DATA_WIDTH-1:0]        s_right_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [DATA_WIDTH-1:0]        m_result_value,
    output logic [ialu_pkg::ERR_WIDTH-1:0]      m_error_code
);

    localparam int W  = DATA_WIDTH;
    localparam int CW = $clog2(W);
    localparam logic [W-1:0] SIGN_MASK = {1'b1, {(W-1){1'b0}}};
    localparam logic [W-1:0] ONE       = W'(1);
    localparam logic [W-1:0] ZERO      = '0;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALU,
        ST_ABS_A,
        ST_ABS_B,
        ST_DIV,
        ST_DIV_FIX,
        ST_MUL,
        ST_POW_CHECK,
        ST_POW_SQ,
        ST_DONE
    } state_t;

    // Where a finished product goes.
    typedef enum logic [1:0] {
        DST_RES,
        DST_PW,
        DST_BASE
    } dst_t;

    state_t                         state_reg;
    dst_t                           dst_reg;
    logic [ialu_pkg::OP_WIDTH-1:0]  op_reg;
    logic [W-1:0]                   a_reg;
    logic [W-1:0]                   b_reg;
    logic [W-1:0]                   mcand_reg;
    logic [W-1:0]                   mplier_reg;
    logic [W-1:0]                   prod_reg;
    logic [W-1:0]                   base_reg;
    logic [W-1:0]                   pw_reg;
    logic [W-1:0]                   exp_reg;
    logic [CW-1:0]                  cnt_reg;
    logic [W-1:0]                   fin_value_reg;
    logic [ialu_pkg::ERR_WIDTH-1:0] fin_error_reg;
    logic                           m_valid_reg;
    logic [W-1:0]                   m_result_value_reg;
    logic [ialu_pkg::ERR_WIDTH-1:0] m_error_code_reg;

    // The one shared adder/subtractor; carry out high means x >= y on a subtract.
    logic [W-1:0] add_x;
    logic [W-1:0] add_y;
    logic         add_sub;
    logic [W:0]   sum;
    logic         carry;
    logic         signs_differ;

    assign signs_differ = a_reg[W-1] ^ b_reg[W-1];

    always_comb begin
        add_x   = prod_reg;
        add_y   = mcand_reg;
        add_sub = 1'b0;
        unique case (state_reg)
            ST_ALU: begin
                unique case (op_reg)
                    ialu_pkg::OP_SUB: begin
                        add_x   = a_reg;
                        add_y   = b_reg;
                        add_sub = 1'b1;
                    end
                    ialu_pkg::OP_NEG: begin
                        add_x   = ZERO;
                        add_y   = a_reg;
                        add_sub = 1'b1;
                    end
                    ialu_pkg::OP_GT: begin
                        add_x   = b_reg ^ SIGN_MASK;
                        add_y   = a_reg ^ SIGN_MASK;
                        add_sub = 1'b1;
                    end
                    ialu_pkg::OP_LT: begin
                        add_x   = a_reg ^ SIGN_MASK;
                        add_y   = b_reg ^ SIGN_MASK;
                        add_sub = 1'b1;
                    end
                    default: begin
                        add_x   = a_reg;
                        add_y   = b_reg;
                        add_sub = 1'b0;
                    end
                endcase
            end
            ST_ABS_A: begin
                add_x   = ZERO;
                add_y   = mplier_reg;
                add_sub = 1'b1;
            end
            ST_ABS_B: begin
                add_x   = ZERO;
                add_y   = mcand_reg;
                add_sub = 1'b1;
            end
            ST_DIV: begin
                add_x   = {prod_reg[W-2:0], mplier_reg[W-1]};
                add_y   = mcand_reg;
                add_sub = 1'b1;
            end
            ST_DIV_FIX: begin
                if (op_reg == ialu_pkg::OP_DIV) begin
                    add_x   = signs_differ ? ZERO : mplier_reg;
                    add_y   = signs_differ ? mplier_reg : ZERO;
                    add_sub = signs_differ;
                end else begin
                    // Floored remainder: the sign of the result follows the divisor.
                    add_x   = a_reg[W-1] ? (signs_differ ? b_reg : ZERO) : prod_reg;
                    add_y   = a_reg[W-1] ? prod_reg : (signs_differ ? b_reg : ZERO);
                    add_sub = a_reg[W-1];
                end
            end
            default: begin
                add_x   = prod_reg;
                add_y   = mcand_reg;
                add_sub = 1'b0;
            end
        endcase
    end

    assign sum   = {1'b0, add_x} + {1'b0, add_y ^ {W{add_sub}}} + (W+1)'(add_sub);
    assign carry = sum[W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready && (state_reg != ST_DONE)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        op_reg        <= s_operation;
                        a_reg         <= s_left_value;
                        b_reg         <= s_right_value;
                        fin_value_reg <= ZERO;
                        fin_error_reg <= ialu_pkg::ERR_NONE;
                        unique case (s_operation)
                            ialu_pkg::OP_MUL: begin
                                mcand_reg  <= s_left_value;
                                mplier_reg <= s_right_value;
                                prod_reg   <= ZERO;
                                dst_reg    <= DST_RES;
                                state_reg  <= ST_MUL;
                            end
                            ialu_pkg::OP_DIV, ialu_pkg::OP_MOD: begin
                                mplier_reg <= s_left_value;
                                mcand_reg  <= s_right_value;
                                if (s_right_value == ZERO) begin
                                    fin_error_reg <= (s_operation == ialu_pkg::OP_DIV) ?
                                                     ialu_pkg::ERR_DIV_ZERO :
                                                     ialu_pkg::ERR_MOD_ZERO;
                                    state_reg     <= ST_DONE;
                                end else begin
                                    state_reg <= ST_ABS_A;
                                end
                            end
                            ialu_pkg::OP_POW: begin
                                base_reg <= s_left_value;
                                pw_reg   <= ONE;
                                exp_reg  <= s_right_value;
                                if (s_right_value[W-1]) begin
                                    fin_error_reg <= ialu_pkg::ERR_NEG_EXP;
                                    state_reg     <= ST_DONE;
                                end else begin
                                    state_reg <= ST_POW_CHECK;
                                end
                            end
                            ialu_pkg::OP_ADD, ialu_pkg::OP_SUB, ialu_pkg::OP_NEG,
                            ialu_pkg::OP_EQ, ialu_pkg::OP_GT, ialu_pkg::OP_LT: begin
                                state_reg <= ST_ALU;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_ALU: begin
                    unique case (op_reg)
                        ialu_pkg::OP_EQ: fin_value_reg <= (a_reg == b_reg) ? ONE : ZERO;
                        ialu_pkg::OP_GT, ialu_pkg::OP_LT:
                            fin_value_reg <= carry ? ZERO : ONE;
                        default: fin_value_reg <= sum[W-1:0];
                    endcase
                    state_reg <= ST_DONE;
                end
                ST_ABS_A: begin
                    if (a_reg[W-1]) begin
                        mplier_reg <= sum[W-1:0];
                    end
                    state_reg <= ST_ABS_B;
                end
                ST_ABS_B: begin
                    if (b_reg[W-1]) begin
                        mcand_reg <= sum[W-1:0];
                    end
                    prod_reg  <= ZERO;
                    cnt_reg   <= '0;
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    // Remainder in prod_reg, quotient bits shift into mplier_reg.
                    prod_reg   <= carry ? sum[W-1:0] : add_x;
                    mplier_reg <= {mplier_reg[W-2:0], carry};
                    cnt_reg    <= cnt_reg + CW'(1);
                    if (cnt_reg == CW'(W-1)) begin
                        state_reg <= ST_DIV_FIX;
                    end
                end
                ST_DIV_FIX: begin
                    if (op_reg == ialu_pkg::OP_MOD && prod_reg == ZERO) begin
                        fin_value_reg <= ZERO;
                    end else begin
                        fin_value_reg <= sum[W-1:0];
                    end
                    state_reg <= ST_DONE;
                end
                ST_MUL: begin
                    if (mplier_reg == ZERO) begin
                        unique case (dst_reg)
                            DST_RES: begin
                                fin_value_reg <= prod_reg;
                                state_reg     <= ST_DONE;
                            end
                            DST_PW: begin
                                pw_reg    <= prod_reg;
                                state_reg <= ST_POW_SQ;
                            end
                            DST_BASE: begin
                                base_reg  <= prod_reg;
                                exp_reg   <= exp_reg >> 1;
                                state_reg <= ST_POW_CHECK;
                            end
                            default: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end else begin
                        if (mplier_reg[0]) begin
                            prod_reg <= sum[W-1:0];
                        end
                        mcand_reg  <= mcand_reg << 1;
                        mplier_reg <= mplier_reg >> 1;
                    end
                end
                ST_POW_CHECK: begin
                    if (exp_reg == ZERO) begin
                        fin_value_reg <= pw_reg;
                        state_reg     <= ST_DONE;
                    end else if (exp_reg[0]) begin
                        mcand_reg  <= pw_reg;
                        mplier_reg <= base_reg;
                        prod_reg   <= ZERO;
                        dst_reg    <= DST_PW;
                        state_reg  <= ST_MUL;
                    end else begin
                        state_reg <= ST_POW_SQ;
                    end
                end
                ST_POW_SQ: begin
                    // No further exponent bits means the square would go unused.
                    if (exp_reg[W-1:1] == ZERO[W-2:0]) begin
                        fin_value_reg <= pw_reg;
                        state_reg     <= ST_DONE;
                    end else begin
                        mcand_reg  <= base_reg;
                        mplier_reg <= base_reg;
                        prod_reg   <= ZERO;
                        dst_reg    <= DST_BASE;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg        <= 1'b1;
                        m_result_value_reg <= fin_value_reg;
                        m_error_code_reg   <= fin_error_reg;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_result_value = m_result_value_reg;
    assign m_error_code   = m_error_code_reg;

    // An error result always carries a zero value.
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_error_code != ialu_pkg::ERR_NONE) |-> (m_result_value == ZERO))
        else $error("error item with nonzero result value");

    // After an item is taken the block is not ready in the following cycle.
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again straight after an accept");

    // The partial remainder must stay below the divisor throughout division.
    a_rem_below_div: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (prod_reg < mcand_reg))
        else $error("partial remainder not below divisor");

    // A finished product never restarts the multiplier directly.
    a_mul_leaves: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) && (mplier_reg == ZERO) |=> (state_reg != ST_MUL))
        else $error("multiplier did not hand over its product");

endmodule

/* bench/tb.sv */
`timescale 1ns / 1ps

module tb;

    localparam int DW = 32;
    localparam int RESET_CYCLES = 12;
    localparam int RANDOM_PER_PHASE = 125;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 80;
    // The quiet limit leaves room for a power item with a full-width exponent.
    localparam int QUIET_LIMIT = 20000;

    typedef logic [ialu_pkg::OP_WIDTH-1:0] op_t;

    localparam op_t OP_UNUSED_LO = 4'd10;
    localparam op_t OP_UNUSED_HI = 4'd15;

    typedef logic signed [DW-1:0] word_t;

    localparam word_t MIN_WORD = {1'b1, {(DW-1){1'b0}}};
    localparam word_t MAX_WORD = {1'b0, {(DW-1){1'b1}}};

    typedef struct {
        word_t value;
        logic [ialu_pkg::ERR_WIDTH-1:0] code;
    } answer_t;

    class alu_answer_board;
        answer_t pending_answers[$];
        int mismatch_count = 0;

        function answer_t evaluate(op_t op, word_t a, word_t b);
            answer_t ans;
            logic [DW-1:0] ma, mb, q, r, acc, base, e;
            logic signs_differ;
            ans.value = '0;
            ans.code = ialu_pkg::ERR_NONE;
            ma = a[DW-1] ? -a : a;
            mb = b[DW-1] ? -b : b;
            signs_differ = a[DW-1] != b[DW-1];
            case (op)
                ialu_pkg::OP_ADD: ans.value = a + b;
                ialu_pkg::OP_SUB: ans.value = a - b;
                ialu_pkg::OP_MUL: ans.value = a * b;
                ialu_pkg::OP_DIV: begin
                    if (b == 0) begin
                        ans.code = ialu_pkg::ERR_DIV_ZERO;
                    end else begin
                        q = ma / mb;
                        ans.value = signs_differ ? -q : q;
                    end
                end
                ialu_pkg::OP_MOD: begin
                    if (b == 0) begin
                        ans.code = ialu_pkg::ERR_MOD_ZERO;
                    end else begin
                        // Floored: a nonzero remainder moves towards the divisor's sign.
                        r = ma % mb;
                        if (a[DW-1]) r = -r;
                        if (r != 0 && signs_differ) r = r + b;
                        ans.value = r;
                    end
                end
                ialu_pkg::OP_POW: begin
                    if (b[DW-1]) begin
                        ans.code = ialu_pkg::ERR_NEG_EXP;
                    end else begin
                        acc = 1;
                        base = a;
                        e = b;
                        while (e != 0) begin
                            if (e[0]) acc = acc * base;
                            base = base * base;
                            e = e >> 1;
                        end
                        ans.value = acc;
                    end
                end
                ialu_pkg::OP_NEG: ans.value = -a;
                ialu_pkg::OP_EQ:  ans.value = (a == b) ? 1 : 0;
                ialu_pkg::OP_GT:  ans.value = (a > b) ? 1 : 0;
                ialu_pkg::OP_LT:  ans.value = (a < b) ? 1 : 0;
                default: ans.value = '0;
            endcase
            return ans;
        endfunction

        function void note_operation(op_t op, word_t a, word_t b);
            pending_answers.push_back(evaluate(op, a, b));
        endfunction

        function void check_answer(word_t value, logic [ialu_pkg::ERR_WIDTH-1:0] code);
            answer_t want;
            if (pending_answers.size() == 0) begin
                $error("result with no item waiting: result_value %0d, error_code %0d",
                       value, code);
                mismatch_count++;
                return;
            end
            want = pending_answers.pop_front();
            if (value !== want.value) begin
                $error("result_value: expected %0d, actual %0d", want.value, value);
                mismatch_count++;
            end
            if (code !== want.code) begin
                $error("error_code: expected %0d, actual %0d", want.code, code);
                mismatch_count++;
            end
        endfunction
    endclass

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    op_t s_operation = ialu_pkg::OP_ADD;
    word_t s_left_value = '0;
    word_t s_right_value = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    word_t m_result_value;
    logic [ialu_pkg::ERR_WIDTH-1:0] m_error_code;

    alu_answer_board board = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int accepted_items = 0;
    int hold_at_item = 32'h7fffffff;
    int quiet_cycles = 0;

    integer_alu_floor_mod_power #(
        .DATA_WIDTH(DW)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_operation(s_operation),
        .s_left_value(s_left_value),
        .s_right_value(s_right_value),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_result_value(m_result_value),
        .m_error_code(m_error_code)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) board.check_answer(m_result_value, m_error_code);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random back-pressure, plus one long hold-off so the block backs up.
    initial begin
        bit held_once;
        held_once = 1'b0;
        forever begin
            @(posedge aclk);
            if (!held_once && accepted_items >= hold_at_item) begin
                held_once = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Valid is only lowered on an idle cycle, never in the step that raises it again.
    task automatic send_item(op_t op, word_t a, word_t b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_operation <= op;
        s_left_value <= a;
        s_right_value <= b;
        do @(posedge aclk); while (!s_ready);
        board.note_operation(op, a, b);
        accepted_items++;
    endtask

    function automatic word_t pick_operand();
        case ($urandom_range(9))
            0: return MIN_WORD;
            1: return MAX_WORD;
            2: return 0;
            3: return -1;
            4: return 1;
            5, 6: return $signed($urandom_range(200)) - 100;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_random_item();
        op_t op;
        word_t a, b;
        if ($urandom_range(19) == 0) op = op_t'($urandom_range(OP_UNUSED_HI, OP_UNUSED_LO));
        else op = op_t'($urandom_range(ialu_pkg::OP_LT, ialu_pkg::OP_ADD));
        a = pick_operand();
        b = pick_operand();
        // Keep most exponents short, since a full-width one is slow.
        if (op == ialu_pkg::OP_POW && $urandom_range(4) != 0) b = $urandom_range(40);
        if ((op == ialu_pkg::OP_DIV || op == ialu_pkg::OP_MOD) && $urandom_range(7) == 0) b = 0;
        send_item(op, a, b);
    endtask

    task automatic send_directed_items();
        send_item(ialu_pkg::OP_ADD, MAX_WORD, 1);
        send_item(ialu_pkg::OP_SUB, MIN_WORD, 1);
        send_item(ialu_pkg::OP_MUL, MAX_WORD, MAX_WORD);
        send_item(ialu_pkg::OP_MUL, MIN_WORD, -1);
        send_item(ialu_pkg::OP_DIV, MIN_WORD, -1);
        send_item(ialu_pkg::OP_DIV, 7, -2);
        send_item(ialu_pkg::OP_DIV, -123, 0);
        send_item(ialu_pkg::OP_MOD, MIN_WORD, -1);
        send_item(ialu_pkg::OP_MOD, -7, 3);
        send_item(ialu_pkg::OP_MOD, 7, -3);
        send_item(ialu_pkg::OP_MOD, -7, -3);
        send_item(ialu_pkg::OP_MOD, 6, -3);
        send_item(ialu_pkg::OP_MOD, 5, 0);
        send_item(ialu_pkg::OP_POW, 0, 0);
        send_item(ialu_pkg::OP_POW, 3, 5);
        send_item(ialu_pkg::OP_POW, -2, 31);
        send_item(ialu_pkg::OP_POW, 2, -1);
        send_item(ialu_pkg::OP_POW, 3, MAX_WORD);
        send_item(ialu_pkg::OP_NEG, MIN_WORD, 77);
        send_item(ialu_pkg::OP_NEG, 5, MIN_WORD);
        send_item(ialu_pkg::OP_EQ, MAX_WORD, MAX_WORD);
        send_item(ialu_pkg::OP_GT, MIN_WORD, MAX_WORD);
        send_item(ialu_pkg::OP_LT, MIN_WORD, MAX_WORD);
        send_item(OP_UNUSED_LO, MAX_WORD, 3);
        send_item(OP_UNUSED_HI, -1, -1);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 35;
        recv_idle_pct = 73;
        send_directed_items();
        repeat (RANDOM_PER_PHASE) send_random_item();

        send_idle_pct = 73;
        recv_idle_pct = 35;
        repeat (RANDOM_PER_PHASE) send_random_item();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_at_item = accepted_items + 30;
        repeat (RANDOM_PER_PHASE) send_random_item();

        s_valid <= 1'b0;
        while (board.pending_answers.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (board.mismatch_count == 0 && board.pending_answers.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/ialu_pkg.sv
rtl/integer_alu_floor_mod_power.sv
bench/tb.sv
